>>> rtl/core/stt_pkg.sv
// Shared types and constants for the source text tokenizer.
`default_nettype none

package stt_pkg;

  localparam int unsigned PosWidth   = 16;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);
  localparam int unsigned OutDataW   = 40;

  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChEquals  = 8'h3D;
  localparam logic [7:0] ChSquote  = 8'h27;
  localparam logic [7:0] ChDquote  = 8'h22;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerZ  = 8'h7A;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperZ  = 8'h5A;
  localparam logic [7:0] ChLowerF  = 8'h66;
  localparam logic [7:0] ChLowerN  = 8'h6E;

  typedef enum logic [2:0] {
    KIND_EOF     = 3'd0,
    KIND_FN      = 3'd1,
    KIND_SYM     = 3'd2,
    KIND_STR     = 3'd3,
    KIND_EQ      = 3'd4,
    KIND_UNKNOWN = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_COMMENT = 4'b0010,
    MODE_SYMBOL  = 4'b0100,
    MODE_STRING  = 4'b1000
  } mode_e;

  typedef struct packed {
    kind_e                kind;
    logic [PosWidth-1:0]  begin_pos;
    logic [PosWidth-1:0]  end_pos;
    logic                 last;
  } tok_t;

  // Tokens produced by one byte, compacted so that token a is always first.
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       a;
    tok_t       b;
  } push_t;

endpackage

`default_nettype wire

>>> rtl/core/stt_scan.sv
// Input byte register, scanner state and per-byte token decode.
`default_nettype none

module stt_scan (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    in_ch_i,
  input  wire logic          room_i,
  output stt_pkg::push_t     push_o
);

  logic                          vld_q;
  logic [7:0]                    ch_q;
  logic                          fire;

  stt_pkg::mode_e                mode_q, mode_d;
  logic                          qd_q, qd_d;
  logic [stt_pkg::PosWidth-1:0]  pos_q, pos_d;
  logic [stt_pkg::PosWidth-1:0]  start_q, start_d;
  logic [1:0]                    len_q, len_d;
  logic                          kw_q, kw_d;

  logic [stt_pkg::PosWidth-1:0]  pos_nx;
  logic                          is_letter, is_space, is_quote, do_idle;
  logic                          p_v, s_v;
  stt_pkg::tok_t                 p_tok, s_tok;
  stt_pkg::kind_e                sym_kind;

  assign fire       = vld_q && room_i;
  assign in_ready_o = !vld_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q <= in_ch_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= stt_pkg::MODE_IDLE;
      qd_q    <= 1'b0;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      kw_q    <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      qd_q    <= qd_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      kw_q    <= kw_d;
    end
  end

  assign pos_nx    = (pos_q == '1) ? pos_q : pos_q + 1'b1;
  assign is_letter = (ch_q >= stt_pkg::ChLowerA && ch_q <= stt_pkg::ChLowerZ) ||
                     (ch_q >= stt_pkg::ChUpperA && ch_q <= stt_pkg::ChUpperZ);
  assign is_space  = (ch_q == stt_pkg::ChSpace) ||
                     (ch_q >= stt_pkg::ChTab && ch_q <= stt_pkg::ChCr);
  assign is_quote  = (ch_q == stt_pkg::ChSquote) || (ch_q == stt_pkg::ChDquote);
  assign sym_kind  = (kw_q && len_q == 2'd2) ? stt_pkg::KIND_FN : stt_pkg::KIND_SYM;

  always_comb begin
    mode_d  = mode_q;
    qd_d    = qd_q;
    pos_d   = pos_q;
    start_d = start_q;
    len_d   = len_q;
    kw_d    = kw_q;
    do_idle = 1'b0;
    p_v     = 1'b0;
    s_v     = 1'b0;
    p_tok   = '{kind: sym_kind, begin_pos: start_q, end_pos: pos_q, last: 1'b0};
    s_tok   = '{kind: stt_pkg::KIND_EOF, begin_pos: pos_q, end_pos: pos_q, last: 1'b1};

    if (fire) begin
      if (ch_q == stt_pkg::ChNul) begin
        // End of text closes any open token, then eof; position restarts.
        if (mode_q == stt_pkg::MODE_SYMBOL) begin
          p_v = 1'b1;
        end else if (mode_q == stt_pkg::MODE_STRING) begin
          p_v        = 1'b1;
          p_tok.kind = stt_pkg::KIND_STR;
        end
        s_v     = 1'b1;
        mode_d  = stt_pkg::MODE_IDLE;
        pos_d   = '0;
        start_d = '0;
        len_d   = '0;
        kw_d    = 1'b0;
      end else begin
        case (mode_q)
          stt_pkg::MODE_COMMENT: begin
            if (ch_q == stt_pkg::ChNewline) begin
              mode_d = stt_pkg::MODE_IDLE;
            end
            pos_d = pos_nx;
          end
          stt_pkg::MODE_STRING: begin
            if (ch_q == (qd_q ? stt_pkg::ChDquote : stt_pkg::ChSquote)) begin
              p_v           = 1'b1;
              p_tok.kind    = stt_pkg::KIND_STR;
              p_tok.end_pos = pos_nx;
              mode_d        = stt_pkg::MODE_IDLE;
            end
            pos_d = pos_nx;
          end
          stt_pkg::MODE_SYMBOL: begin
            if (is_letter) begin
              kw_d  = (len_q == 2'd1) ? (kw_q && ch_q == stt_pkg::ChLowerN) : 1'b0;
              len_d = (len_q == 2'd3) ? len_q : len_q + 2'd1;
              pos_d = pos_nx;
            end else begin
              p_v     = 1'b1;
              len_d   = '0;
              kw_d    = 1'b0;
              do_idle = 1'b1;
            end
          end
          stt_pkg::MODE_IDLE: begin
            do_idle = 1'b1;
          end
          default: begin
            mode_d = stt_pkg::MODE_IDLE;
          end
        endcase

        // The byte that ends a symbol is handled here as an idle-mode byte.
        if (do_idle) begin
          mode_d = stt_pkg::MODE_IDLE;
          pos_d  = pos_nx;
          if (is_space) begin
            mode_d = stt_pkg::MODE_IDLE;
          end else if (ch_q == stt_pkg::ChHash) begin
            mode_d = stt_pkg::MODE_COMMENT;
          end else if (is_letter) begin
            mode_d  = stt_pkg::MODE_SYMBOL;
            start_d = pos_q;
            len_d   = 2'd1;
            kw_d    = (ch_q == stt_pkg::ChLowerF);
          end else if (is_quote) begin
            mode_d  = stt_pkg::MODE_STRING;
            start_d = pos_q;
            qd_d    = (ch_q == stt_pkg::ChDquote);
          end else begin
            s_v           = 1'b1;
            s_tok.kind    = (ch_q == stt_pkg::ChEquals) ? stt_pkg::KIND_EQ
                                                        : stt_pkg::KIND_UNKNOWN;
            s_tok.end_pos = pos_nx;
          end
        end
      end
    end

    push_o.cnt    = {1'b0, p_v} + {1'b0, s_v};
    push_o.a      = p_v ? p_tok : s_tok;
    push_o.a.last = !(p_v && s_v);
    push_o.b      = s_tok;
  end

  a_eof_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ch_q == stt_pkg::ChNul) |=> (pos_q == '0 && mode_q == stt_pkg::MODE_IDLE))
    else $error("eof did not restart the scanner");

  a_pair_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.cnt == 2'd2) |-> (!push_o.a.last && push_o.b.last &&
      (push_o.a.kind == stt_pkg::KIND_FN || push_o.a.kind == stt_pkg::KIND_SYM ||
       push_o.a.kind == stt_pkg::KIND_STR)))
    else $error("bad token pair from one byte");

endmodule

`default_nettype wire

>>> rtl/core/stt_fifo.sv
// Small token queue that takes up to two tokens per cycle and issues one.
`default_nettype none

module stt_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire stt_pkg::push_t push_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output stt_pkg::tok_t       out_tok_o
);

  stt_pkg::tok_t                  mem_q [stt_pkg::QueueDepth];
  logic [stt_pkg::QueuePtrW-1:0]  wr_q, rd_q;
  logic [stt_pkg::QueueCntW-1:0]  cnt_q;
  logic                           pop;
  logic [stt_pkg::QueuePtrW-1:0]  wr_nx;

  assign out_valid_o = (cnt_q != '0);
  assign out_tok_o   = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  // Room is granted only for a full pair so that any byte can be taken.
  assign room_o      = (cnt_q <= stt_pkg::QueueCntW'(stt_pkg::QueueDepth - 2));
  assign wr_nx       = wr_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.a;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nx] <= push_i.b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + stt_pkg::QueuePtrW'(push_i.cnt);
      rd_q  <= rd_q + stt_pkg::QueuePtrW'(pop);
      cnt_q <= cnt_q + stt_pkg::QueueCntW'(push_i.cnt) - stt_pkg::QueueCntW'(pop);
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |->
      ({1'b0, cnt_q} + (stt_pkg::QueueCntW + 1)'(push_i.cnt) <=
       (stt_pkg::QueueCntW + 1)'(stt_pkg::QueueDepth)))
    else $error("token queue overflow");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= stt_pkg::QueueCntW'(stt_pkg::QueueDepth))
    else $error("token queue count out of range");

endmodule

`default_nettype wire

>>> rtl/core/source_text_tokenizer_unit.sv
// Path: an accepted byte is held in the input byte register and scanned there; its tokens
// are written to the token queue, whose head is offered on the output.
// Throughput: one byte per cycle while the queue has room; a byte that yields two tokens
// leaves as two output transfers; the four-entry token queue holds the extra token.
// Reset: rst_ni is asynchronous and active low; it empties the queue and returns the
// scanner to idle with position zero.
`default_nettype none

module source_text_tokenizer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [2:0] kind, [18:3] begin_pos, [34:19] end_pos
  output logic             m_axis_tlast
);

  stt_pkg::push_t push;
  logic           room;
  stt_pkg::tok_t  head;

  stt_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_ch_i    (s_axis_tdata),
    .room_i     (room),
    .push_o     (push)
  );

  stt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_tok_o   (head)
  );

  assign m_axis_tdata = {5'd0, head.end_pos, head.begin_pos, head.kind};
  assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

>>> verif/tb_source_text_tokenizer_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the source text tokenizer: directed table and random text.
module tb_source_text_tokenizer_unit;

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned RandomBytes = 374;
  localparam int unsigned IdlePercent = 31;
  localparam int unsigned MaxPrinted  = 40;
  localparam logic [stt_pkg::PosWidth-1:0] PosMax = '1;

  typedef struct packed {
    logic [7:0]    ch;
    logic          typed;
    stt_pkg::tok_t tok;
  } text_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  source_text_tokenizer_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // Scanner state mirrored by the token predictor.
  stt_pkg::mode_e               scan_mode;
  logic                         scan_dquote;
  logic [stt_pkg::PosWidth-1:0] scan_pos;
  logic [stt_pkg::PosWidth-1:0] scan_start;
  logic [1:0]                   scan_len;
  logic                         scan_kw;

  stt_pkg::tok_t scan_out [2];
  int unsigned   scan_cnt;
  stt_pkg::tok_t expected_tokens [$];

  int unsigned mismatch_count = 0;
  int unsigned bytes_fed      = 0;
  bit          tx_no_idle     = 1'b0;
  int unsigned rx_cycle       = 0;
  int unsigned quiet_cycles   = 0;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) $display("MISMATCH: %s", msg);
  endtask

  function automatic logic [stt_pkg::PosWidth-1:0] pos_next(
      input logic [stt_pkg::PosWidth-1:0] p);
    return (p == PosMax) ? p : p + 1'b1;
  endfunction

  function automatic bit is_letter(input logic [7:0] ch);
    return (ch >= stt_pkg::ChLowerA && ch <= stt_pkg::ChLowerZ) ||
           (ch >= stt_pkg::ChUpperA && ch <= stt_pkg::ChUpperZ);
  endfunction

  function automatic bit is_blank(input logic [7:0] ch);
    return ch == stt_pkg::ChSpace || (ch >= stt_pkg::ChTab && ch <= stt_pkg::ChCr);
  endfunction

  task automatic push_token(input stt_pkg::kind_e k, input logic [stt_pkg::PosWidth-1:0] b,
                            input logic [stt_pkg::PosWidth-1:0] e);
    stt_pkg::tok_t t;
    t.kind      = k;
    t.begin_pos = b;
    t.end_pos   = e;
    t.last      = 1'b0;
    scan_out[scan_cnt] = t;
    scan_cnt++;
  endtask

  task automatic close_symbol();
    push_token((scan_kw && scan_len == 2'd2) ? stt_pkg::KIND_FN : stt_pkg::KIND_SYM,
               scan_start, scan_pos);
  endtask

  task automatic scan_from_idle(input logic [7:0] ch);
    if (is_blank(ch)) begin
    end else if (ch == stt_pkg::ChHash) begin
      scan_mode = stt_pkg::MODE_COMMENT;
    end else if (is_letter(ch)) begin
      scan_mode  = stt_pkg::MODE_SYMBOL;
      scan_start = scan_pos;
      scan_len   = 2'd1;
      scan_kw    = (ch == stt_pkg::ChLowerF);
    end else if (ch == stt_pkg::ChSquote || ch == stt_pkg::ChDquote) begin
      scan_mode   = stt_pkg::MODE_STRING;
      scan_start  = scan_pos;
      scan_dquote = (ch == stt_pkg::ChDquote);
    end else if (ch == stt_pkg::ChEquals) begin
      push_token(stt_pkg::KIND_EQ, scan_pos, pos_next(scan_pos));
    end else begin
      push_token(stt_pkg::KIND_UNKNOWN, scan_pos, pos_next(scan_pos));
    end
    scan_pos = pos_next(scan_pos);
  endtask

  // Computes the tokens that one source byte yields and advances the mirrored state.
  task automatic scan_byte(input logic [7:0] ch);
    logic [7:0] closing;
    scan_cnt = 0;
    if (ch == stt_pkg::ChNul) begin
      if (scan_mode == stt_pkg::MODE_SYMBOL) close_symbol();
      else if (scan_mode == stt_pkg::MODE_STRING)
        push_token(stt_pkg::KIND_STR, scan_start, scan_pos);
      push_token(stt_pkg::KIND_EOF, scan_pos, scan_pos);
      scan_mode  = stt_pkg::MODE_IDLE;
      scan_pos   = '0;
      scan_start = '0;
      scan_len   = 2'd0;
      scan_kw    = 1'b0;
    end else if (scan_mode == stt_pkg::MODE_COMMENT) begin
      if (ch == stt_pkg::ChNewline) scan_mode = stt_pkg::MODE_IDLE;
      scan_pos = pos_next(scan_pos);
    end else if (scan_mode == stt_pkg::MODE_STRING) begin
      closing = scan_dquote ? stt_pkg::ChDquote : stt_pkg::ChSquote;
      if (ch == closing) begin
        push_token(stt_pkg::KIND_STR, scan_start, pos_next(scan_pos));
        scan_mode = stt_pkg::MODE_IDLE;
      end
      scan_pos = pos_next(scan_pos);
    end else if (scan_mode == stt_pkg::MODE_SYMBOL) begin
      if (is_letter(ch)) begin
        scan_kw = (scan_len == 2'd1) ? (scan_kw && ch == stt_pkg::ChLowerN) : 1'b0;
        if (scan_len < 2'd3) scan_len++;
        scan_pos = pos_next(scan_pos);
      end else begin
        close_symbol();
        scan_mode = stt_pkg::MODE_IDLE;
        scan_len  = 2'd0;
        scan_kw   = 1'b0;
        scan_from_idle(ch);
      end
    end else begin
      scan_from_idle(ch);
    end
    if (scan_cnt > 0) scan_out[scan_cnt-1].last = 1'b1;
  endtask

  function automatic text_row_t free_row(input logic [7:0] ch);
    text_row_t r;
    r       = '0;
    r.ch    = ch;
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic text_row_t typed_row(input logic [7:0] ch, input stt_pkg::kind_e k,
                                          input logic [stt_pkg::PosWidth-1:0] b,
                                          input logic [stt_pkg::PosWidth-1:0] e);
    text_row_t r;
    r               = '0;
    r.ch            = ch;
    r.typed         = 1'b1;
    r.tok.kind      = k;
    r.tok.begin_pos = b;
    r.tok.end_pos   = e;
    r.tok.last      = 1'b1;
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] ch);
    while (!tx_no_idle && $urandom_range(0, 99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic feed_byte(input text_row_t row);
    send_byte(row.ch);
    scan_byte(row.ch);
    if (row.typed) begin
      expected_tokens.push_back(row.tok);
    end else begin
      for (int unsigned i = 0; i < scan_cnt; i++) expected_tokens.push_back(scan_out[i]);
    end
    bytes_fed++;
    // One long stretch of back-to-back requests in the middle of the random text.
    tx_no_idle = (bytes_fed >= 150 && bytes_fed < 260);
  endtask

  function automatic logic [7:0] random_letter();
    logic [7:0] off;
    off = 8'($urandom_range(0, 25));
    return $urandom_range(0, 1) ? stt_pkg::ChLowerA + off : stt_pkg::ChUpperA + off;
  endfunction

  function automatic logic [7:0] random_unknown();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (is_letter(c) || is_blank(c) || c == stt_pkg::ChHash || c == stt_pkg::ChEquals ||
           c == stt_pkg::ChSquote || c == stt_pkg::ChDquote);
    return c;
  endfunction

  // Mostly well-formed tokens with random content; about a fifth of the picks is raw noise.
  task automatic write_random_text(input int unsigned n_bytes);
    int unsigned stop;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  quote;
    logic [7:0]  c;
    stop = bytes_fed + n_bytes;
    while (bytes_fed < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        feed_byte(free_row(8'($urandom_range(0, 255))));
      end else if (pick < 40) begin
        len = $urandom_range(1, 5);
        if ($urandom_range(0, 2) == 0) begin
          feed_byte(free_row(stt_pkg::ChLowerF));
          feed_byte(free_row(stt_pkg::ChLowerN));
          len = $urandom_range(0, 2);
        end
        repeat (len) feed_byte(free_row(random_letter()));
      end else if (pick < 55) begin
        quote = $urandom_range(0, 1) ? stt_pkg::ChDquote : stt_pkg::ChSquote;
        feed_byte(free_row(quote));
        repeat ($urandom_range(0, 6)) begin
          do c = 8'($urandom_range(1, 255)); while (c == quote);
          feed_byte(free_row(c));
        end
        if ($urandom_range(0, 99) < 85) feed_byte(free_row(quote));
      end else if (pick < 62) begin
        feed_byte(free_row(stt_pkg::ChHash));
        repeat ($urandom_range(0, 5)) begin
          do c = 8'($urandom_range(1, 255)); while (c == stt_pkg::ChNewline);
          feed_byte(free_row(c));
        end
        if ($urandom_range(0, 9) != 0) feed_byte(free_row(stt_pkg::ChNewline));
      end else if (pick < 72) begin
        c = $urandom_range(0, 1) ? stt_pkg::ChSpace
                                 : 8'($urandom_range(stt_pkg::ChTab, stt_pkg::ChCr));
        feed_byte(free_row(c));
      end else if (pick < 82) begin
        feed_byte(free_row(stt_pkg::ChEquals));
      end else if (pick < 92) begin
        feed_byte(free_row(random_unknown()));
      end else begin
        feed_byte(free_row(stt_pkg::ChNul));
      end
    end
  endtask

  // Receiver: random stalls, two long hold-offs, and one stretch that never stalls.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if ((rx_cycle >= 300 && rx_cycle < 420) || (rx_cycle >= 2000 && rx_cycle < 2150))
        m_axis_tready <= 1'b0;
      else if (rx_cycle >= 800 && rx_cycle < 1100)
        m_axis_tready <= 1'b1;
      else
        m_axis_tready <= ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  always @(posedge clk_i) begin
    stt_pkg::tok_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("unexpected token data %h last %b", m_axis_tdata,
                                  m_axis_tlast));
      end else begin
        want = expected_tokens.pop_front();
        if (m_axis_tdata[2:0] !== want.kind || m_axis_tdata[18:3] !== want.begin_pos ||
            m_axis_tdata[34:19] !== want.end_pos || m_axis_tlast !== want.last)
          report_mismatch($sformatf(
            "got kind %0d range %0d..%0d last %b, want kind %0d range %0d..%0d last %b",
            m_axis_tdata[2:0], m_axis_tdata[18:3], m_axis_tdata[34:19], m_axis_tlast,
            want.kind, want.begin_pos, want.end_pos, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    text_row_t directed [26];
    scan_mode   = stt_pkg::MODE_IDLE;
    scan_dquote = 1'b0;
    scan_pos    = '0;
    scan_start  = '0;
    scan_len    = 2'd0;
    scan_kw     = 1'b0;
    directed = '{
      typed_row(stt_pkg::ChNul, stt_pkg::KIND_EOF, 16'd0, 16'd0),
      typed_row(stt_pkg::ChEquals, stt_pkg::KIND_EQ, 16'd0, 16'd1),
      typed_row(8'hFF, stt_pkg::KIND_UNKNOWN, 16'd1, 16'd2),
      free_row(stt_pkg::ChLowerF), free_row(stt_pkg::ChLowerN), free_row(stt_pkg::ChEquals),
      free_row(stt_pkg::ChUpperZ), free_row(stt_pkg::ChNul),
      free_row(stt_pkg::ChDquote), free_row(stt_pkg::ChSquote), free_row(stt_pkg::ChDquote),
      free_row(stt_pkg::ChHash), free_row("x"), free_row(stt_pkg::ChNewline),
      free_row(stt_pkg::ChUpperA), free_row(stt_pkg::ChSquote), free_row(stt_pkg::ChNul),
      free_row(stt_pkg::ChHash),
      typed_row(stt_pkg::ChNul, stt_pkg::KIND_EOF, 16'd1, 16'd1),
      free_row(stt_pkg::ChLowerF), free_row(stt_pkg::ChLowerN), free_row(stt_pkg::ChLowerA),
      free_row(stt_pkg::ChSpace),
      typed_row(8'h80, stt_pkg::KIND_UNKNOWN, 16'd4, 16'd5),
      free_row(stt_pkg::ChTab),
      typed_row(stt_pkg::ChNul, stt_pkg::KIND_EOF, 16'd6, 16'd6)
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) feed_byte(directed[i]);
    write_random_text(RandomBytes);

    s_axis_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (expected_tokens.size() != 0)
      report_mismatch($sformatf("%0d tokens never arrived", expected_tokens.size()));

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/stt_pkg.sv
rtl/core/stt_scan.sv
rtl/core/stt_fifo.sv
rtl/core/source_text_tokenizer_unit.sv
verif/tb_source_text_tokenizer_unit.sv
